// File: rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and codes of the sparse pattern remap unit: request codes,
// controller states and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package spr_pkg;

	// request codes carried on req_type
	localparam logic [1:0] REQ_PTR = 2'd0;
	localparam logic [1:0] REQ_ENT = 2'd1;
	localparam logic [1:0] REQ_QRY = 2'd2;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_END,
		S_START,
		S_LOAD,
		S_CMP
	} state_t;

	// entry store read address select
	typedef enum logic [1:0] {
		ENT_CUR,
		ENT_LOAD,
		ENT_NEXT
	} ent_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic     wr_ptr;
		logic     wr_ent;
		logic     latch_query;
		logic     row_sel_next;
		logic     latch_end;
		logic     load_cursor;
		ent_sel_t ent_sel;
		logic     step;
		logic     emit_hit;
		logic     emit_miss;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic row_in_range;
		logic reload;
		logic cur_lt_end;
		logic col_lt;
		logic col_eq;
	} sts_t;

endpackage

// File: rtl/spr_ctrl.sv
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer of the sparse pattern remap unit: takes each word, issues
// store writes, and walks a query through the row pointer reads and the
// cursor scan of the entry store.
// ----------------------------------------------------------------------------
module spr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    req_type,
	input  spr_pkg::sts_t sts,
	output spr_pkg::cmd_t cmd,
	output logic          busy
);
	import spr_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.ent_sel = ENT_CUR;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req_type)
						REQ_PTR: cmd.wr_ptr = 1'b1;
						REQ_ENT: cmd.wr_ent = 1'b1;
						REQ_QRY: begin
							if (sts.row_in_range) begin
								cmd.latch_query = 1'b1;
								state_d = S_END;
							end else begin
								cmd.emit_miss = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_END: begin
				// read the next row's start: the end of this row
				cmd.row_sel_next = 1'b1;
				state_d = S_START;
			end
			S_START: begin
				cmd.latch_end = 1'b1;
				if (sts.reload) begin
					state_d = S_LOAD;
				end else begin
					cmd.ent_sel = ENT_CUR;
					state_d = S_CMP;
				end
			end
			S_LOAD: begin
				cmd.load_cursor = 1'b1;
				cmd.ent_sel = ENT_LOAD;
				state_d = S_CMP;
			end
			S_CMP: begin
				// prefetch the entry after the cursor on every scan cycle
				cmd.ent_sel = ENT_NEXT;
				if (!sts.cur_lt_end) begin
					cmd.emit_miss = 1'b1;
					state_d = S_IDLE;
				end else if (sts.col_lt) begin
					cmd.step = 1'b1;
				end else if (sts.col_eq) begin
					cmd.step = 1'b1;
					cmd.emit_hit = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.emit_miss = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_hit && cmd.emit_miss))
		else $error("hit and miss issued together");

	a_load_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> ($past(state_q) == S_START))
		else $error("cursor load not preceded by start pointer read");

	a_query_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.emit_hit || cmd.emit_miss) && state_q != S_IDLE) |=> (state_q == S_IDLE))
		else $error("controller did not return to idle after a result");

endmodule

// File: rtl/spr_dp.sv
// ----------------------------------------------------------------------------
// spr_dp
// Datapath of the sparse pattern remap unit: row start store, column and
// value stores, the row cursor, and the registered result word.
// ----------------------------------------------------------------------------
module spr_dp #(
	parameter int MAX_ROWS     = 256,
	parameter int MAX_NONZEROS = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [12:0]   index,
	input  logic [12:0]   pointer,
	input  logic [7:0]    row,
	input  logic [9:0]    col,
	input  logic [63:0]   value,
	input  spr_pkg::cmd_t cmd,
	output spr_pkg::sts_t sts,
	output logic [63:0]   out_value,
	output logic          matched,
	output logic          result_valid
);
	import spr_pkg::*;

	localparam int RA = $clog2(MAX_ROWS + 1);
	localparam int EA = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
	localparam int CW = $clog2(MAX_NONZEROS + 1);

	logic [12:0] row_mem [MAX_ROWS + 1];
	logic [9:0]  col_mem [MAX_NONZEROS];
	logic [63:0] val_mem [MAX_NONZEROS];

	logic [12:0]   row_rd_q;
	logic [9:0]    col_rd_q;
	logic [63:0]   val_rd_q;
	logic [7:0]    row_q;
	logic [9:0]    col_q;
	logic [CW-1:0] end_q;
	logic [CW-1:0] cursor_q;
	logic [7:0]    cursor_row_q;
	logic          cursor_valid_q;
	logic [63:0]   out_value_q;
	logic          matched_q;
	logic          result_valid_q;

	logic          ptr_ok;
	logic          ent_ok;
	logic [RA-1:0] row_addr;
	logic [EA-1:0] ent_addr;
	logic [CW-1:0] rd_sat;

	assign ptr_ok = (32'(index) <= MAX_ROWS);
	assign ent_ok = (32'(index) < MAX_NONZEROS);

	// saturate a stored row pointer to the entry store depth
	assign rd_sat = (32'(row_rd_q) > MAX_NONZEROS) ? CW'(MAX_NONZEROS) : CW'(row_rd_q);

	// pick row store address: this row or the next one
	assign row_addr = cmd.row_sel_next ? RA'({1'b0, row_q} + 9'd1) : RA'(row_q);

	// pick entry store address
	always_comb begin
		case (cmd.ent_sel)
			ENT_CUR:  ent_addr = EA'(cursor_q);
			ENT_LOAD: ent_addr = EA'(rd_sat);
			ENT_NEXT: ent_addr = EA'(cursor_q + CW'(1));
			default:  ent_addr = EA'(cursor_q);
		endcase
	end

	// row start store
	always_ff @(posedge clk) begin
		if (cmd.wr_ptr && ptr_ok) begin
			row_mem[RA'(index)] <= pointer;
		end
		row_rd_q <= row_mem[row_addr];
	end

	// column and value stores
	always_ff @(posedge clk) begin
		if (cmd.wr_ent && ent_ok) begin
			col_mem[EA'(index)] <= col;
			val_mem[EA'(index)] <= value;
		end
		col_rd_q <= col_mem[ent_addr];
		val_rd_q <= val_mem[ent_addr];
	end

	// hold query fields and row end
	always_ff @(posedge clk) begin
		if (cmd.latch_query) begin
			row_q <= row;
			col_q <= col;
		end
		if (cmd.latch_end) begin
			end_q <= rd_sat;
		end
	end

	// advance or reload the row cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q       <= '0;
			cursor_row_q   <= '0;
			cursor_valid_q <= 1'b0;
		end else if (cmd.load_cursor) begin
			cursor_q       <= rd_sat;
			cursor_row_q   <= row_q;
			cursor_valid_q <= 1'b1;
		end else if (cmd.step) begin
			cursor_q <= cursor_q + CW'(1);
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit_hit || cmd.emit_miss;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hit) begin
			out_value_q <= val_rd_q;
			matched_q   <= 1'b1;
		end else if (cmd.emit_miss) begin
			out_value_q <= '0;
			matched_q   <= 1'b0;
		end
	end

	// status to the controller
	assign sts.row_in_range = (32'(row) < MAX_ROWS);
	assign sts.reload       = !cursor_valid_q || (cursor_row_q != row_q);
	assign sts.cur_lt_end   = (cursor_q < end_q);
	assign sts.col_lt       = (col_rd_q < col_q);
	assign sts.col_eq       = (col_rd_q == col_q);

	assign out_value    = out_value_q;
	assign matched      = matched_q;
	assign result_valid = result_valid_q;

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_valid_q |-> (32'(cursor_q) <= MAX_NONZEROS))
		else $error("cursor beyond entry store depth");

	a_step_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (cursor_q < end_q))
		else $error("cursor stepped past row end");

	a_match_from_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && matched_q) |-> $past(cmd.emit_hit))
		else $error("matched result without a hit");

endmodule

// File: rtl/sparse_pattern_remap_unit.sv
// ----------------------------------------------------------------------------
// sparse_pattern_remap_unit
// Projects a compressed-row source matrix onto queried target positions.
// Pointer and entry words load the stores; a query word returns the source
// value at (row, col), or zero with matched low.
//
//   channel  | handshake           | fields
//   ---------+---------------------+------------------------------------------
//   request  | start / busy        | req_type index pointer row col value
//   result   | result_valid strobe | out_value matched
//
// Write words and unused request codes leave the controller idle and give
// no result. A query whose row is out of range answers in the cycle after
// it is taken. Any other query reads the row end (S_END, S_START), loads
// the cursor from the row start in S_LOAD when the row changes or the
// cursor is not yet loaded, and scans in S_CMP past each entry it skips.
// Reset clears the cursor, the result strobe and the controller; the stores
// are not cleared. A result is strobed on result_valid for one cycle; the
// receiver cannot stall it.
// ----------------------------------------------------------------------------
module sparse_pattern_remap_unit #(
	parameter int MAX_ROWS     = 256,
	parameter int MAX_NONZEROS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [12:0] index,
	input  logic [12:0] pointer,
	input  logic [7:0]  row,
	input  logic [9:0]  col,
	input  logic [63:0] value,
	output logic        result_valid,
	output logic [63:0] out_value,
	output logic        matched
);
	import spr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	spr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	// stores, cursor and result word
	spr_dp #(
		.MAX_ROWS     (MAX_ROWS),
		.MAX_NONZEROS (MAX_NONZEROS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.index        (index),
		.pointer      (pointer),
		.row          (row),
		.col          (col),
		.value        (value),
		.cmd          (cmd),
		.sts          (sts),
		.out_value    (out_value),
		.matched      (matched),
		.result_valid (result_valid)
	);

endmodule
